// File: sv/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [20:0] BMP_LAST    = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [15:0] HIGH_SURR   = 16'hD800;
  localparam logic [15:0] LOW_SURR    = 16'hDC00;
  localparam int          QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        text_end;
  } out_req_t;

  typedef struct packed {
    logic [1:0]  rep_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic        fin;
  } job_t;

endpackage

// File: sv/u8u16_front.sv
// Front end: decodes each UTF-8 byte into a job of replacement and tail units.
`timescale 1ns / 1ps

module u8u16_front
  import u8u16_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_req_t in_req,
  output logic    job_push,
  output job_t    job,
  input  logic    queue_full
);

  logic [20:0] pp_r, pp_nxt;
  logic [1:0]  exp_r, exp_nxt;
  logic [1:0]  acc_r, acc_nxt;

  logic [7:0]  b;
  logic        fin;
  logic        take;
  logic [20:0] pp_cat;
  logic [1:0]  acc_inc;
  logic [20:0] supp;
  logic        bad_point;
  logic        lead;

  assign in_ready = !queue_full;
  assign take     = in_valid && in_ready;
  assign b        = in_req.text_byte;
  assign fin      = in_req.final_byte;
  assign pp_cat   = {pp_r[14:0], b[5:0]};
  assign acc_inc  = acc_r + 2'd1;
  assign supp     = pp_cat - SUPP_BASE;
  assign bad_point = (pp_cat > MAX_POINT) || ((pp_cat >= SURR_FIRST) && (pp_cat <= SURR_LAST));

  always_comb begin
    pp_nxt       = pp_r;
    exp_nxt      = exp_r;
    acc_nxt      = acc_r;
    lead         = 1'b0;
    job.rep_cnt  = 2'd0;
    job.tail_cnt = 2'd0;
    job.tail0    = REPL_UNIT;
    job.tail1    = REPL_UNIT;
    job.fin      = fin;
    if ((exp_r != 2'd0) && (b[7:6] == 2'b10)) begin
      pp_nxt  = pp_cat;
      acc_nxt = acc_inc;
      if (acc_inc >= exp_r) begin
        pp_nxt  = '0;
        exp_nxt = 2'd0;
        acc_nxt = 2'd0;
        if (bad_point || (pp_cat <= BMP_LAST)) begin
          job.tail_cnt = 2'd1;
          job.tail0    = bad_point ? REPL_UNIT : pp_cat[15:0];
        end else begin
          job.tail_cnt = 2'd2;
          job.tail0    = HIGH_SURR + {6'd0, supp[19:10]};
          job.tail1    = LOW_SURR + {6'd0, supp[9:0]};
        end
      end else if (fin) begin
        job.rep_cnt = acc_inc + 2'd1;
        pp_nxt      = '0;
        exp_nxt     = 2'd0;
        acc_nxt     = 2'd0;
      end
    end else begin
      if (exp_r != 2'd0) begin
        job.rep_cnt = acc_inc;
      end
      pp_nxt  = '0;
      exp_nxt = 2'd0;
      acc_nxt = 2'd0;
      if (!b[7]) begin
        job.tail_cnt = 2'd1;
        job.tail0    = {8'd0, b};
      end else if (b[7:5] == 3'b110) begin
        pp_nxt  = {16'd0, b[4:0]};
        exp_nxt = 2'd1;
        lead    = 1'b1;
      end else if (b[7:4] == 4'b1110) begin
        pp_nxt  = {17'd0, b[3:0]};
        exp_nxt = 2'd2;
        lead    = 1'b1;
      end else if (b[7:3] == 5'b11110) begin
        pp_nxt  = {18'd0, b[2:0]};
        exp_nxt = 2'd3;
        lead    = 1'b1;
      end else begin
        job.tail_cnt = 2'd1;
      end
      if (fin && lead) begin
        job.tail_cnt = 2'd1;
        pp_nxt       = '0;
        exp_nxt      = 2'd0;
      end
    end
  end

  assign job_push = take && ((job.rep_cnt != 2'd0) || (job.tail_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r  <= '0;
      exp_r <= 2'd0;
      acc_r <= 2'd0;
    end else if (take) begin
      pp_r  <= pp_nxt;
      exp_r <= exp_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: sv/u8u16_queue.sv
// Two-entry job queue between the decoder front end and the unit emitter.
`timescale 1ns / 1ps

module u8u16_queue
  import u8u16_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t       q_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign head      = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: sv/u8u16_back.sv
// Back end: emits the units of each queued job one per cycle into the output register while out_ready is high.
`timescale 1ns / 1ps

module u8u16_back
  import u8u16_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_ready,
  input  job_t     head,
  output logic     job_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_req
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_req_t   out_req_r;
  out_req_t   unit;
  logic       load;
  logic [2:0] total;
  logic [1:0] tail_idx;
  logic       last;

  assign total    = {1'b0, head.rep_cnt} + {1'b0, head.tail_cnt};
  assign last     = ({1'b0, idx_r} + 3'd1) == total;
  assign tail_idx = idx_r - head.rep_cnt;
  assign load     = job_ready && (!out_valid_r || out_ready);
  assign job_pop  = load && last;

  always_comb begin
    if (idx_r < head.rep_cnt) begin
      unit.code_unit = REPL_UNIT;
    end else if (tail_idx == 2'd0) begin
      unit.code_unit = head.tail0;
    end else begin
      unit.code_unit = head.tail1;
    end
    unit.run_last = last;
    unit.text_end = last && head.fin;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_req_r <= unit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

// File: sv/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder.
//
// Input channel in_valid/in_ready/in_req carries one UTF-8 byte per request,
// with final_byte set on the last byte of a text. Output channel
// out_valid/out_ready/out_req carries one UTF-16 code unit per request;
// run_last marks the last unit a byte causes, text_end the last unit of a
// text. Malformed input yields U+FFFD units.
// The first unit of a byte passes the job queue and then the output
// register. Throughput: one byte per cycle while each byte gives at most
// one unit and out_ready stays high. A byte that gives more units holds
// the emitter until all of them are out; a two-entry job queue lets the
// decoder keep taking bytes meanwhile.
// A continuation that only extends an open sequence produces no unit.
// Reset empties the queue and the output register and closes any open
// sequence; no clearing pass is needed. When the receiver stalls, the
// output register holds its unit, the queue fills, then in_ready drops.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top
  import u8u16_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_req
);

  logic job_push;
  job_t job;
  logic queue_full;
  logic job_pop;
  logic job_ready;
  job_t head;

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .job_push   (job_push),
    .job        (job),
    .queue_full (queue_full)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_job  (job),
    .full      (queue_full),
    .pop       (job_pop),
    .not_empty (job_ready),
    .head      (head)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_ready (job_ready),
    .head      (head),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

endmodule
